FILE: rtl/divisor_function_unit_macros.svh
// Assertion helpers shared by the design files.
`ifndef DIVISOR_FUNCTION_UNIT_MACROS_SVH
`define DIVISOR_FUNCTION_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DFU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DFU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/dfu_pkg.sv
package dfu_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int RESULT_WIDTH = 36;
    localparam int PERFECT_COUNT = 8;
    localparam int PIDX_WIDTH   = $clog2(PERFECT_COUNT + 1);
    // Internal accumulator width; wider than the result so saturation can be seen.
    localparam int ACC_WIDTH    = RESULT_WIDTH + 1;

    localparam logic [2:0] FUNC_DIGIT_SUM   = 3'd0;
    localparam logic [2:0] FUNC_DIVISOR_SUM = 3'd1;
    localparam logic [2:0] FUNC_FACTOR_CNT  = 3'd2;
    localparam logic [2:0] FUNC_PERFECT     = 3'd3;
    localparam logic [2:0] FUNC_PERFECT_CNT = 3'd4;

    localparam logic [RESULT_WIDTH-2:0] RESULT_MAX = '1;

    function automatic logic [63:0] perfect_num(input logic [PIDX_WIDTH-1:0] idx);
        logic [63:0] r;
        begin
            unique case (idx)
                4'd0:    r = 64'd6;
                4'd1:    r = 64'd28;
                4'd2:    r = 64'd496;
                4'd3:    r = 64'd8128;
                4'd4:    r = 64'd33550336;
                4'd5:    r = 64'd8589869056;
                4'd6:    r = 64'd137438691328;
                4'd7:    r = 64'd2305843008139952128;
                default: r = '1;
            endcase
            return r;
        end
    endfunction

    // Control from the sequencer to the serial divider and multiplier.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: rtl/divisor_function_unit.sv
// Arithmetic-function unit: each input word carries a function code and a
// signed 32-bit value, and one 36-bit signed result word comes back. Codes:
// 0 decimal digit sum (negated for a negative value), 1 sum of divisors of
// |value| (saturating at 2^35-1), 2 prime factor count with multiplicity
// (0 below two), 3 perfect-number test (1 also for zero), 4 number of perfect
// numbers dividing value; other codes give 0. One word is processed at a
// time. Every division, including the by-ten steps of the digit sum, runs in
// a shared restoring divider, and each multiply of the divisor sum runs in a
// shift-and-add multiplier. The digit sum makes one division per decimal
// digit; the factor functions make at least one division per trial divisor
// up to sqrt(value), so a large prime takes far longer than a small or smooth
// value. The perfect divisor count makes one division per table entry not
// above value, at most five. The result register lets the next word be
// accepted while a result waits.
module divisor_function_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] func, [34:3] value, [39:35] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [35:0] result, [39:36] zero
);
    `include "divisor_function_unit_macros.svh"

    localparam int VW = dfu_pkg::VALUE_WIDTH;
    localparam int AW = dfu_pkg::ACC_WIDTH;
    localparam int RW = dfu_pkg::RESULT_WIDTH;
    localparam int PW = dfu_pkg::PIDX_WIDTH;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DIG   = 10'b0000000010,  // divide remaining magnitude by ten
        ST_DIGW  = 10'b0000000100,
        ST_TRY   = 10'b0000001000,  // test loop bound and divide n by p
        ST_TRYW  = 10'b0000010000,
        ST_MUL   = 10'b0000100000,  // fold a prime power term into the sum
        ST_MULW  = 10'b0001000000,
        ST_PCHK  = 10'b0010000000,  // divide by, or compare with, next perfect number
        ST_PCHKW = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [2:0]     func_reg, func_next;
    logic           neg_reg, neg_next;
    logic [VW-1:0]  mag_reg, mag_next;   // |value| or the remaining n
    logic [VW-1:0]  p_reg, p_next;       // trial divisor
    logic [AW-1:0]  acc_reg, acc_next;   // digit sum, factor count, sigma or perfect result
    logic [AW-1:0]  pk_reg, pk_next;     // current prime power
    logic [AW-1:0]  term_reg, term_next; // 1 + p + ... + p^k
    logic           hit_reg, hit_next;   // p divided n at least once
    logic           final_reg, final_next;
    logic [PW-1:0]  pidx_reg, pidx_next;
    logic [RW-1:0]  res_reg, res_next;
    logic           mval_reg, mval_next;

    dfu_pkg::div_ctrl_t div_ctrl, mul_ctrl;
    dfu_pkg::div_stat_t div_stat, mul_stat;
    logic [AW-1:0]      div_a, div_b, div_q, div_r;
    logic [AW-1:0]      mul_a, mul_b, mul_p;
    logic [2:0]         in_func;
    logic [VW-1:0]      in_value;
    logic               accept;
    logic [63:0]        perf;

    assign in_func  = s_tdata[2:0];
    assign in_value = s_tdata[VW+2:3];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign perf     = dfu_pkg::perfect_num(pidx_reg);

    dfu_serial_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_a),
        .divisor   (div_b),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    dfu_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .stat    (mul_stat),
        .product (mul_p)
    );

    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        p_next     = p_reg;
        acc_next   = acc_reg;
        pk_next    = pk_reg;
        term_next  = term_reg;
        hit_next   = hit_reg;
        final_next = final_reg;
        pidx_next  = pidx_reg;
        res_next   = res_reg;
        mval_next  = mval_reg;
        div_ctrl.start = 1'b0;
        mul_ctrl.start = 1'b0;
        div_a = AW'(mag_reg);
        div_b = AW'(p_reg);
        mul_a = acc_reg;
        mul_b = final_reg ? AW'(mag_reg) + AW'(1) : term_reg;
        if (mval_reg && m_tready) mval_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next = in_func;
                    neg_next  = in_value[VW-1];
                    mag_next  = in_value[VW-1] ? VW'(-in_value) : in_value;
                    p_next    = VW'(2);
                    acc_next  = '0;
                    pidx_next = '0;
                    hit_next  = 1'b0;
                    final_next = 1'b0;
                    unique case (in_func)
                        dfu_pkg::FUNC_DIGIT_SUM: state_next = ST_DIG;
                        dfu_pkg::FUNC_DIVISOR_SUM: begin
                            acc_next   = AW'(1);
                            pk_next    = AW'(1);
                            term_next  = AW'(1);
                            state_next = ST_TRY;
                        end
                        dfu_pkg::FUNC_FACTOR_CNT: state_next = ST_TRY;
                        dfu_pkg::FUNC_PERFECT: begin
                            // Compare against the table one entry a cycle.
                            acc_next   = AW'(in_value == '0);
                            state_next = ST_PCHK;
                        end
                        dfu_pkg::FUNC_PERFECT_CNT: state_next = ST_PCHK;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_DIG: begin
                if (mag_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    div_b = AW'(10);
                    div_ctrl.start = 1'b1;
                    state_next = ST_DIGW;
                end
            end
            ST_DIGW: begin
                if (div_stat.done) begin
                    acc_next   = acc_reg + div_r;
                    mag_next   = VW'(div_q);
                    state_next = ST_DIG;
                end
            end
            ST_TRY: begin
                // The loop runs while p*p <= n; a division n/p gives the bound.
                if (func_reg == dfu_pkg::FUNC_DIVISOR_SUM && mag_reg == '0) begin
                    acc_next   = '0;
                    state_next = ST_OUT;
                end else if (func_reg == dfu_pkg::FUNC_FACTOR_CNT && neg_reg) begin
                    state_next = ST_OUT;
                end else if (AW'(p_reg) > AW'(mag_reg)) begin
                    // p exceeds n, so p*p > n as well: the loop is over.
                    if (hit_reg && func_reg == dfu_pkg::FUNC_DIVISOR_SUM) begin
                        // The last strip left n at one; its term is still open.
                        hit_next = 1'b0;
                        mul_ctrl.start = 1'b1;
                        state_next = ST_MULW;
                    end else if (mag_reg > VW'(1)) begin
                        if (func_reg == dfu_pkg::FUNC_FACTOR_CNT) begin
                            acc_next   = acc_reg + AW'(1);
                            state_next = ST_OUT;
                        end else begin
                            final_next = 1'b1;
                            mul_b = AW'(mag_reg) + AW'(1);
                            mul_ctrl.start = 1'b1;
                            state_next = ST_MULW;
                        end
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    div_ctrl.start = 1'b1;
                    state_next = ST_TRYW;
                end
            end
            ST_TRYW: begin
                if (div_stat.done) begin
                    if (div_r == '0) begin
                        // p divides n: strip one factor and try p again.
                        mag_next = VW'(div_q);
                        hit_next = 1'b1;
                        if (func_reg == dfu_pkg::FUNC_FACTOR_CNT) begin
                            acc_next = acc_reg + AW'(1);
                        end else begin
                            state_next = ST_MUL;
                        end
                        if (func_reg == dfu_pkg::FUNC_FACTOR_CNT) state_next = ST_TRY;
                    end else if (hit_reg && func_reg == dfu_pkg::FUNC_DIVISOR_SUM) begin
                        // Done with this prime: fold term into the sum.
                        hit_next = 1'b0;
                        mul_ctrl.start = 1'b1;
                        state_next = ST_MULW;
                    end else if (div_q < AW'(p_reg)) begin
                        // p > n/p: the trial loop is over.
                        hit_next = 1'b0;
                        if (mag_reg > VW'(1)) begin
                            if (func_reg == dfu_pkg::FUNC_FACTOR_CNT) begin
                                acc_next   = acc_reg + AW'(1);
                                state_next = ST_OUT;
                            end else begin
                                final_next = 1'b1;
                                mul_b = AW'(mag_reg) + AW'(1);
                                mul_ctrl.start = 1'b1;
                                state_next = ST_MULW;
                            end
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        hit_next = 1'b0;
                        p_next   = p_reg + VW'(1);
                        state_next = ST_TRY;
                    end
                end
            end
            ST_MUL: begin
                // pk *= p, then term += pk, on the shared multiplier.
                mul_a = pk_reg;
                mul_b = AW'(p_reg);
                if (!mul_stat.busy && !mul_stat.done && !final_reg) begin
                    mul_ctrl.start = 1'b1;
                    final_next = 1'b0;
                    state_next = ST_MULW;
                    hit_next   = 1'b1;
                    pidx_next  = PW'(1);   // marks a prime power step
                end
            end
            ST_MULW: begin
                mul_a = (pidx_reg == PW'(1)) ? pk_reg : acc_reg;
                mul_b = (pidx_reg == PW'(1)) ? AW'(p_reg)
                      : (final_reg ? AW'(mag_reg) + AW'(1) : term_reg);
                if (mul_stat.done) begin
                    if (pidx_reg == PW'(1)) begin
                        pidx_next = '0;
                        pk_next   = mul_p;
                        term_next = (term_reg + mul_p > AW'(dfu_pkg::RESULT_MAX))
                                  ? AW'(dfu_pkg::RESULT_MAX) : term_reg + mul_p;
                        state_next = ST_TRY;
                    end else begin
                        acc_next  = mul_p;
                        pk_next   = AW'(1);
                        term_next = AW'(1);
                        if (final_reg) begin
                            state_next = ST_OUT;
                        end else begin
                            p_next     = p_reg + VW'(1);
                            state_next = ST_TRY;
                        end
                    end
                end
            end
            ST_PCHK: begin
                if (pidx_reg == PW'(dfu_pkg::PERFECT_COUNT) || neg_reg || mag_reg == '0) begin
                    state_next = ST_OUT;
                end else if (func_reg == dfu_pkg::FUNC_PERFECT) begin
                    if (perf == 64'(mag_reg)) acc_next = AW'(1);
                    pidx_next = pidx_reg + PW'(1);
                end else if (perf > 64'(mag_reg)) begin
                    state_next = ST_OUT;
                end else begin
                    div_b = AW'(perf);
                    div_ctrl.start = 1'b1;
                    state_next = ST_PCHKW;
                end
            end
            ST_PCHKW: begin
                div_b = AW'(perf);
                if (div_stat.done) begin
                    if (div_r == '0) acc_next = acc_reg + AW'(1);
                    pidx_next  = pidx_reg + PW'(1);
                    state_next = ST_PCHK;
                end
            end
            ST_OUT: begin
                if (!mval_reg) begin
                    if (func_reg == dfu_pkg::FUNC_DIGIT_SUM && neg_reg)
                        res_next = RW'(-acc_reg);
                    else if (func_reg > dfu_pkg::FUNC_PERFECT_CNT)
                        res_next = '0;
                    else
                        res_next = acc_reg[RW-1:0];
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
        func_reg  <= func_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
        pk_reg    <= pk_next;
        term_reg  <= term_next;
        hit_reg   <= hit_next;
        final_reg <= final_next;
        pidx_reg  <= pidx_next;
        res_reg   <= res_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = {4'b0, res_reg};

    `DFU_ASSERT_NXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata))
    `DFU_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `DFU_ASSERT_IMP(a_div_only_in_wait, aclk, aresetn, div_stat.done,
                    state_reg == ST_DIGW || state_reg == ST_TRYW || state_reg == ST_PCHKW)
    `DFU_ASSERT_IMP(a_div_busy_in_wait, aclk, aresetn, div_stat.busy,
                    state_reg == ST_DIGW || state_reg == ST_TRYW || state_reg == ST_PCHKW)

endmodule

FILE: rtl/dfu_serial_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
module dfu_serial_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dfu_pkg::div_ctrl_t              ctrl,
    input  logic [dfu_pkg::ACC_WIDTH-1:0]   dividend,
    input  logic [dfu_pkg::ACC_WIDTH-1:0]   divisor,
    output dfu_pkg::div_stat_t              stat,
    output logic [dfu_pkg::ACC_WIDTH-1:0]   quotient,
    output logic [dfu_pkg::ACC_WIDTH-1:0]   remainder
);
    `include "divisor_function_unit_macros.svh"

    localparam int W  = dfu_pkg::ACC_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
        if (ctrl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[W]) begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `DFU_ASSERT_NXT(a_div_done_after_busy, aclk, aresetn, done_next, !busy_reg)
    `DFU_ASSERT_IMP(a_div_idle_count, aclk, aresetn, !busy_reg, cnt_reg == '0 || done_reg == 1'b0)
    `DFU_ASSERT_IMP(a_div_done_not_busy, aclk, aresetn, done_reg, !busy_reg)

endmodule

FILE: rtl/dfu_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, saturating result.
module dfu_serial_mul (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dfu_pkg::div_ctrl_t              ctrl,
    input  logic [dfu_pkg::ACC_WIDTH-1:0]   op_a,
    input  logic [dfu_pkg::ACC_WIDTH-1:0]   op_b,
    output dfu_pkg::div_stat_t              stat,
    output logic [dfu_pkg::ACC_WIDTH-1:0]   product
);
    `include "divisor_function_unit_macros.svh"

    localparam int W  = dfu_pkg::ACC_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam logic [W-1:0] SAT = W'(dfu_pkg::RESULT_MAX);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  mcd_reg, mcd_next;
    logic [W-1:0]  mpr_reg, mpr_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    sum;

    // The multiplicand is shifted left each step; once it or the sum passes
    // the saturation value while bits remain, the product is pinned.
    always_comb begin
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpr_next  = mpr_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum       = {1'b0, acc_reg} + {1'b0, mcd_reg};
        if (ctrl.start) begin
            acc_next  = '0;
            mcd_next  = op_a;
            mpr_next  = op_b;
            ovf_next  = (op_a == '0) || (op_b == '0) ? 1'b0 : (op_a > SAT || op_b > SAT);
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mpr_reg[0]) begin
                if (sum > {1'b0, SAT}) ovf_next = 1'b1;
                else acc_next = sum[W-1:0];
            end
            if (mpr_reg[W-1:1] != '0 && mcd_reg > (SAT >> 1)) ovf_next = 1'b1;
            mcd_next = {mcd_reg[W-2:0], 1'b0};
            mpr_next = {1'b0, mpr_reg[W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpr_reg <= mpr_next;
        ovf_reg <= ovf_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = ovf_reg ? SAT : acc_reg;

    `DFU_ASSERT_IMP(a_mul_done_not_busy, aclk, aresetn, done_reg, !busy_reg)
    `DFU_ASSERT_IMP(a_mul_in_range, aclk, aresetn, done_reg, product <= SAT)

endmodule

FILE: sim/tb_divisor_function_unit.sv
module tb_divisor_function_unit;

    // Spare function codes; the unit answers each of them with zero.
    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    // Cycles without any accepted word before the run is declared hung. The slowest
    // operand used here is a prime near 2^16 through trial division.
    localparam int STALL_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 600;
    localparam int DRAIN_CYCLES  = 100;
    localparam logic [63:0] SUM_CAP = (64'd1 << (dfu_pkg::RESULT_WIDTH - 1)) - 64'd1;

    localparam logic [63:0] PERFECT_NUMS [dfu_pkg::PERFECT_COUNT] = '{
        64'd6, 64'd28, 64'd496, 64'd8128, 64'd33550336, 64'd8589869056,
        64'd137438691328, 64'd2305843008139952128
    };

    typedef struct packed {
        logic [2:0]                       func;
        logic signed [31:0]               value;
        bit                               fixed;   // expected result typed into the row
        logic [dfu_pkg::RESULT_WIDTH-1:0] result;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{dfu_pkg::FUNC_DIGIT_SUM,   32'sd0,           1'b1, 36'd0},
        '{dfu_pkg::FUNC_DIGIT_SUM,   32'sd2147483647,  1'b0, 36'd0},
        '{dfu_pkg::FUNC_DIGIT_SUM,   -32'sd2147483648, 1'b0, 36'd0},
        '{dfu_pkg::FUNC_DIGIT_SUM,   -32'sd1,          1'b1, -36'sd1},
        '{dfu_pkg::FUNC_DIVISOR_SUM, 32'sd0,           1'b1, 36'd0},
        '{dfu_pkg::FUNC_DIVISOR_SUM, 32'sd1,           1'b1, 36'd1},
        '{dfu_pkg::FUNC_DIVISOR_SUM, -32'sd2147483648, 1'b0, 36'd0},
        '{dfu_pkg::FUNC_DIVISOR_SUM, 32'sd2147483646,  1'b0, 36'd0},
        '{dfu_pkg::FUNC_DIVISOR_SUM, -32'sd12,         1'b1, 36'd28},
        '{dfu_pkg::FUNC_FACTOR_CNT,  32'sd1,           1'b1, 36'd0},
        '{dfu_pkg::FUNC_FACTOR_CNT,  -32'sd5,          1'b1, 36'd0},
        '{dfu_pkg::FUNC_FACTOR_CNT,  32'sd1073741824,  1'b1, 36'd30},
        '{dfu_pkg::FUNC_FACTOR_CNT,  32'sd2147483646,  1'b0, 36'd0},
        '{dfu_pkg::FUNC_PERFECT,     32'sd0,           1'b1, 36'd1},
        '{dfu_pkg::FUNC_PERFECT,     32'sd1,           1'b1, 36'd0},
        '{dfu_pkg::FUNC_PERFECT,     -32'sd6,          1'b1, 36'd0},
        '{dfu_pkg::FUNC_PERFECT,     32'sd33550336,    1'b1, 36'd1},
        '{dfu_pkg::FUNC_PERFECT,     32'sd2147483647,  1'b1, 36'd0},
        '{dfu_pkg::FUNC_PERFECT_CNT, 32'sd0,           1'b1, 36'd0},
        '{dfu_pkg::FUNC_PERFECT_CNT, -32'sd28,         1'b1, 36'd0},
        '{dfu_pkg::FUNC_PERFECT_CNT, 32'sd2147221504,  1'b0, 36'd0},
        '{FUNC_SPARE_5,              32'sd12345,       1'b1, 36'd0},
        '{FUNC_SPARE_6,              -32'sd1,          1'b1, 36'd0},
        '{FUNC_SPARE_7,              32'sd2147483647,  1'b1, 36'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    logic [dfu_pkg::RESULT_WIDTH-1:0] pending_results [$];
    int error_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;

    divisor_function_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Computes the result word the unit should give for one function code and operand.
    function automatic logic [dfu_pkg::RESULT_WIDTH-1:0] arith_result(
            logic [2:0] func, logic signed [31:0] value);
        longint signed wide;
        logic [63:0] mag, n, acc, p, pk, term, r;
        bit neg;
        begin
            wide = value;
            neg = wide < 0;
            mag = neg ? 64'(-wide) : 64'(wide);
            r = '0;
            case (func)
                dfu_pkg::FUNC_DIGIT_SUM: begin
                    n = mag;
                    while (n != 0) begin
                        r += n % 10;
                        n /= 10;
                    end
                    if (neg) r = -r;
                end
                dfu_pkg::FUNC_DIVISOR_SUM: begin
                    n = mag;
                    acc = 64'd1;
                    if (n != 0) begin
                        for (p = 2; p <= n / p; p++) begin
                            if (n % p == 0) begin
                                pk = 1;
                                term = 1;
                                while (n % p == 0) begin
                                    n /= p;
                                    pk *= p;
                                    term += pk;
                                end
                                acc = acc * term;
                            end
                        end
                        if (n > 1) acc = acc * (n + 1);
                        r = (acc > SUM_CAP) ? SUM_CAP : acc;
                    end
                end
                dfu_pkg::FUNC_FACTOR_CNT: begin
                    if (!neg) begin
                        n = mag;
                        for (p = 2; p <= n / p; p++) begin
                            while (n % p == 0) begin
                                n /= p;
                                r++;
                            end
                        end
                        if (n > 1) r++;
                    end
                end
                dfu_pkg::FUNC_PERFECT: begin
                    if (mag == 0) r = 1;
                    else if (!neg)
                        foreach (PERFECT_NUMS[i]) if (PERFECT_NUMS[i] == mag) r = 1;
                end
                dfu_pkg::FUNC_PERFECT_CNT: begin
                    if (!neg && mag != 0)
                        foreach (PERFECT_NUMS[i])
                            if (PERFECT_NUMS[i] <= mag && mag % PERFECT_NUMS[i] == 0) r++;
                end
                default: r = '0;
            endcase
            return r[dfu_pkg::RESULT_WIDTH-1:0];
        end
    endfunction

    task automatic report_mismatch(string what, logic [dfu_pkg::RESULT_WIDTH-1:0] want,
                                   logic [dfu_pkg::RESULT_WIDTH-1:0] got);
        begin
            $display("ERROR t=%0t %s: expected %h, got %h", $time, what, want, got);
            error_count++;
        end
    endtask

    // Offers one word, idling beforehand at the current rate, and records the
    // expected result once the unit takes it. Valid is only lowered when a gap
    // actually follows, so back-to-back words keep it high.
    task automatic send_word(logic [2:0] func, logic signed [31:0] value, bit fixed,
                             logic [dfu_pkg::RESULT_WIDTH-1:0] typed);
        logic [dfu_pkg::RESULT_WIDTH-1:0] expected;
        begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {5'd0, value, func};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            expected = fixed ? typed : arith_result(func, value);
            pending_results = {pending_results, expected};
        end
    endtask

    // Random operand shaped by function: trial-division functions get small or smooth
    // large magnitudes, perfect functions often table multiples, the rest any value.
    task automatic send_random_word();
        int pick;
        logic [2:0] func;
        logic signed [31:0] value;
        begin
            pick = $urandom_range(0, 19);
            func = (pick < 17) ? 3'(pick % 5) : 3'(5 + pick - 17);
            value = $urandom;
            case (func)
                dfu_pkg::FUNC_DIVISOR_SUM, dfu_pkg::FUNC_FACTOR_CNT: begin
                    if ($urandom_range(3) == 0)
                        value = 32'($urandom_range(1, 255)) << $urandom_range(0, 23);
                    else
                        value = 32'($urandom_range(0, 65535));
                    if ($urandom_range(4) == 0) value = -value;
                end
                dfu_pkg::FUNC_PERFECT: begin
                    if ($urandom_range(2) == 0)
                        value = 32'(PERFECT_NUMS[$urandom_range(0, 4)]);
                end
                dfu_pkg::FUNC_PERFECT_CNT: begin
                    if ($urandom_range(2) == 0)
                        value = 32'(PERFECT_NUMS[$urandom_range(0, 4)])
                                * 32'($urandom_range(1, 60));
                end
                default: ;
            endcase
            send_word(func, value, 1'b0, '0);
        end
    endtask

    // The receiver stalls at random according to the current rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Every accepted result word is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing expected", '0, m_tdata[35:0]);
            end else begin
                if (m_tdata[35:0] !== pending_results[0])
                    report_mismatch("result", pending_results[0], m_tdata[35:0]);
                void'(pending_results.pop_front());
            end
        end
    end

    // The watchdog restarts whenever a word moves on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase one: slow-ish sender, very slow receiver; directed rows go first.
        tx_idle_pct = 28;
        rx_idle_pct = 79;
        foreach (DIRECTED[i])
            send_word(DIRECTED[i].func, DIRECTED[i].value, DIRECTED[i].fixed,
                      DIRECTED[i].result);
        repeat (RANDOM_WORDS / 3) send_random_word();

        // Hold the sender until the unit has fully drained before switching rates.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);

        tx_idle_pct = 79;
        rx_idle_pct = 28;
        repeat (RANDOM_WORDS / 3) send_random_word();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_WORDS / 3) send_random_word();
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
